// ----- rtl/core/emcf_pkg.sv -----
// Shared constants, types and helpers of the exact-match class frequency block.
package emcf_pkg;

    // Sizing of the pattern and class tables.
    localparam int FEATURE_BITS = 8;
    localparam int CLASS_COUNT  = 8;
    localparam int COUNT_BITS   = 16;

    // Widths of the input and result fields.
    localparam int FEATURES_W   = 8;
    localparam int CLASS_ID_W   = 3;
    localparam int OUT_CLASS_W  = 3;
    localparam int FRAC_BITS    = 16;
    localparam int PROB_BITS    = FRAC_BITS + 1;

    // Derived table geometry. Class counts are addressed as {pattern, class}.
    localparam int PATTERN_DEPTH   = 1 << FEATURE_BITS;
    localparam int CLASS_BITS      = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int CLASS_SLOTS     = 1 << CLASS_BITS;
    localparam int COUNT_ADDR_BITS = FEATURE_BITS + CLASS_BITS;
    localparam int COUNT_DEPTH     = 1 << COUNT_ADDR_BITS;

    // Queries report at most eight classes.
    localparam int OUT_CLASSES  = (CLASS_COUNT < 8) ? CLASS_COUNT : 8;
    localparam int SCAN_BITS    = $clog2(OUT_CLASSES + 1);

    // One quotient bit per divider step.
    localparam int DIV_STEPS    = PROB_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Opcode of an input request.
    localparam logic OP_TRAIN = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRAIN_RD,
        ST_TRAIN_WR,
        ST_QUERY_RD,
        ST_QUERY_TOT,
        ST_SCAN,
        ST_COUNT,
        ST_DIV,
        ST_EMIT,
        ST_MISS
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic latch_in;
        logic rd_train;
        logic wr_train;
        logic rd_total;
        logic latch_total;
        logic rd_count;
        logic div_load;
        logic div_step;
        logic out_load;
        logic out_miss;
        logic scan_clr;
        logic scan_inc;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic cls_valid;
        logic total_zero;
        logic seen_bit;
        logic cls_last;
        logic scan_end;
        logic div_last;
        logic out_free;
    } dp_status_t;

    // Saturating increment of a count.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (&v) ? v : COUNT_BITS'(v + 1'b1);
        return r;
    endfunction

endpackage

// ----- rtl/core/emcf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module emcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/emcf_ctrl.sv -----
// Controller state machine that sequences training, queries and the clearing pass.
module emcf_ctrl import emcf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       in_opcode,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       s_tready
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = (in_opcode == OP_QUERY) ? ST_QUERY_RD : ST_TRAIN_RD;
                end
            end
            ST_TRAIN_RD: begin
                if (status.cls_valid) begin
                    cmd.rd_train = 1'b1;
                    state_next   = ST_TRAIN_WR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TRAIN_WR: begin
                cmd.wr_train = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_QUERY_RD: begin
                cmd.rd_total = 1'b1;
                state_next   = ST_QUERY_TOT;
            end
            ST_QUERY_TOT: begin
                cmd.latch_total = 1'b1;
                cmd.scan_clr    = 1'b1;
                state_next      = status.total_zero ? ST_MISS : ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_end) begin
                    state_next = ST_IDLE;
                end else if (status.seen_bit) begin
                    cmd.rd_count = 1'b1;
                    state_next   = ST_COUNT;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_COUNT: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.cls_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.scan_inc = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_MISS: begin
                if (status.out_free) begin
                    cmd.out_miss = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/core/emcf_datapath.sv -----
// Datapath: count tables, class scan, serial divider and result register.
module emcf_datapath import emcf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic [FEATURES_W-1:0]  in_features,
    input  logic [CLASS_ID_W-1:0]  in_class_id,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic                   out_matched,
    output logic [OUT_CLASS_W-1:0] out_class,
    output logic [PROB_BITS-1:0]   out_probability,
    output logic                   out_last
);

    // Request registers.
    logic [FEATURE_BITS-1:0]    pat_reg;
    logic [CLASS_ID_W-1:0]      cls_reg;

    // Control counters and class bookkeeping.
    logic [COUNT_ADDR_BITS-1:0] clr_reg;
    logic [SCAN_BITS-1:0]       scan_reg;
    logic [CLASS_SLOTS-1:0]     seen_reg;

    // Divider state.
    logic [COUNT_BITS-1:0]      total_reg;
    logic [COUNT_BITS:0]        rem_reg;
    logic [PROB_BITS-1:0]       quo_reg;
    logic [DIV_CNT_BITS-1:0]    div_cnt_reg;
    logic                       first_reg;

    // Result register.
    logic                       m_valid_reg;
    logic                       o_matched_reg;
    logic [OUT_CLASS_W-1:0]     o_class_reg;
    logic [PROB_BITS-1:0]       o_prob_reg;
    logic                       o_last_reg;

    // Memory connections.
    logic                       cnt_we;
    logic [COUNT_ADDR_BITS-1:0] cnt_waddr;
    logic [COUNT_BITS-1:0]      cnt_wdata;
    logic                       cnt_re;
    logic [COUNT_ADDR_BITS-1:0] cnt_raddr;
    logic [COUNT_BITS-1:0]      cnt_rdata;
    logic                       tot_we;
    logic [FEATURE_BITS-1:0]    tot_waddr;
    logic [COUNT_BITS-1:0]      tot_wdata;
    logic [COUNT_BITS-1:0]      tot_rdata;

    logic [CLASS_BITS-1:0]      train_cls;
    logic [CLASS_BITS-1:0]      scan_cls;
    logic [COUNT_ADDR_BITS-1:0] train_addr;
    logic [COUNT_ADDR_BITS-1:0] scan_addr;
    logic [CLASS_SLOTS-1:0]     above;
    logic [COUNT_BITS:0]        trial;
    logic [COUNT_BITS:0]        denom;
    logic                       ge;

    assign train_cls  = CLASS_BITS'(cls_reg);
    assign scan_cls   = CLASS_BITS'(scan_reg);
    assign train_addr = {pat_reg, train_cls};
    assign scan_addr  = {pat_reg, scan_cls};

    // Table write and read selection; the clearing pass writes zeros.
    always_comb begin
        cnt_we    = cmd.clr_step | cmd.wr_train;
        cnt_waddr = cmd.clr_step ? clr_reg : train_addr;
        cnt_wdata = cmd.clr_step ? '0 : sat_inc(cnt_rdata);
        cnt_re    = cmd.rd_train | cmd.rd_count;
        cnt_raddr = cmd.rd_train ? train_addr : scan_addr;
        tot_we    = cmd.clr_step | cmd.wr_train;
        tot_waddr = cmd.clr_step ? clr_reg[FEATURE_BITS-1:0] : pat_reg;
        tot_wdata = cmd.clr_step ? '0 : sat_inc(tot_rdata);
    end

    emcf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (COUNT_DEPTH)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    emcf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PATTERN_DEPTH)
    ) u_total_ram (
        .aclk  (aclk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .re    (cmd.rd_train | cmd.rd_total),
        .raddr (pat_reg),
        .rdata (tot_rdata)
    );

    // Seen classes above the current scan position decide the last flag.
    always_comb begin
        for (int i = 0; i < CLASS_SLOTS; i++) begin
            above[i] = seen_reg[i] && (i > int'(scan_reg)) && (i < OUT_CLASSES);
        end
    end

    // One restoring division step; the first step compares the count itself.
    always_comb begin
        denom = {1'b0, total_reg};
        trial = first_reg ? rem_reg : {rem_reg[COUNT_BITS-1:0], 1'b0};
        ge    = (trial >= denom);
    end

    // Request latch, counters and bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            seen_reg <= '0;
            scan_reg <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_reg <= COUNT_ADDR_BITS'(clr_reg + 1'b1);
            end
            if (cmd.wr_train) begin
                seen_reg[train_cls] <= 1'b1;
            end
            if (cmd.scan_clr) begin
                scan_reg <= '0;
            end else if (cmd.scan_inc) begin
                scan_reg <= SCAN_BITS'(scan_reg + 1'b1);
            end
        end
    end

    // Payload registers of the request and the divider.
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            pat_reg <= FEATURE_BITS'(in_features);
            cls_reg <= in_class_id;
        end
        if (cmd.latch_total) begin
            total_reg <= tot_rdata;
        end
        if (cmd.div_load) begin
            rem_reg     <= {1'b0, cnt_rdata};
            quo_reg     <= '0;
            div_cnt_reg <= '0;
            first_reg   <= 1'b1;
        end else if (cmd.div_step) begin
            rem_reg     <= ge ? (trial - denom) : trial;
            quo_reg     <= {quo_reg[PROB_BITS-2:0], ge};
            div_cnt_reg <= DIV_CNT_BITS'(div_cnt_reg + 1'b1);
            first_reg   <= 1'b0;
        end
    end

    // Result register: loaded when empty or being taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load || cmd.out_miss) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_matched_reg <= 1'b1;
            o_class_reg   <= OUT_CLASS_W'(scan_reg);
            o_prob_reg    <= quo_reg;
            o_last_reg    <= ~|above;
        end else if (cmd.out_miss) begin
            o_matched_reg <= 1'b0;
            o_class_reg   <= '0;
            o_prob_reg    <= '0;
            o_last_reg    <= 1'b1;
        end
    end

    // Status toward the controller.
    always_comb begin
        status.clr_done   = (clr_reg == COUNT_ADDR_BITS'(COUNT_DEPTH - 1));
        status.cls_valid  = ({1'b0, cls_reg} < (CLASS_ID_W + 1)'(CLASS_COUNT))
                            || (CLASS_COUNT >= (1 << CLASS_ID_W));
        status.total_zero = (tot_rdata == '0);
        status.seen_bit   = seen_reg[scan_cls];
        status.cls_last   = ~|above;
        status.scan_end   = (scan_reg == SCAN_BITS'(OUT_CLASSES));
        status.div_last   = (div_cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1));
        status.out_free   = !m_valid_reg || m_tready;
    end

    assign m_tvalid        = m_valid_reg;
    assign out_matched     = o_matched_reg;
    assign out_class       = o_class_reg;
    assign out_probability = o_prob_reg;
    assign out_last        = o_last_reg;

endmodule

// ----- rtl/core/exact_match_class_frequency.sv -----
// A train request goes through accept, table read and table write.
// A query looks up its pattern total, then for each seen class scans, reads the count,
// runs the serial divider over the 17-bit quotient and loads the result; an unseen class only advances the scan.
// Requests are handled one at a time.
// After reset a clearing pass zeroes all 2048 count entries and the pattern totals with s_tready low.
// Results wait in an output register, so the next request is taken while one is pending.
module exact_match_class_frequency import emcf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // features [7:0], class_id [10:8], zero [15:11]
    input  logic        s_tuser,   // opcode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // matched [0], out_class [3:1], probability [20:4], zero
    output logic        m_tlast
);

    ctrl_cmd_t              cmd;
    dp_status_t             status;
    logic                   out_matched;
    logic [OUT_CLASS_W-1:0] out_class;
    logic [PROB_BITS-1:0]   out_probability;

    emcf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .in_opcode (s_tuser),
        .status    (status),
        .cmd       (cmd),
        .s_tready  (s_tready)
    );

    emcf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_features     (s_tdata[FEATURES_W-1:0]),
        .in_class_id     (s_tdata[FEATURES_W +: CLASS_ID_W]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_matched     (out_matched),
        .out_class       (out_class),
        .out_probability (out_probability),
        .out_last        (m_tlast)
    );

    // Pack the result fields.
    assign m_tdata = {3'b000, out_probability, out_class, out_matched};

    // The clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready during the clearing pass");

    // A result for an unknown pattern always closes its run.
    a_miss_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tlast && m_tdata[20:4] == 17'd0))
        else $error("unmatched result is not a lone zero result");

    // A fraction never exceeds one.
    a_prob_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:4] <= 17'h10000))
        else $error("probability above one");

    // No request is taken while the datapath is still dividing.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_tready)
        else $error("input ready during division");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the exact-match class frequency block on its request streams.
`timescale 1ns / 100ps

module testbench;
    import emcf_pkg::*;

    // One request as the sender offers it, with the idle cycles that precede it.
    typedef struct {
        logic                  opcode;
        logic [FEATURES_W-1:0] features;
        logic [CLASS_ID_W-1:0] class_id;
        int unsigned           gap;
    } request_t;

    // One class frequency result as the block reports it.
    typedef struct {
        logic                   matched;
        logic [OUT_CLASS_W-1:0] out_class;
        logic [PROB_BITS-1:0]   probability;
        logic                   last;
    } frequency_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    exact_match_class_frequency uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the count tables and the seen-class mask.
    logic [COUNT_BITS-1:0]  class_tally [PATTERN_DEPTH][CLASS_COUNT];
    logic [COUNT_BITS-1:0]  pattern_tally [PATTERN_DEPTH];
    logic [CLASS_COUNT-1:0] seen_mask;

    request_t    request_queue[$];
    frequency_t  frequency_queue[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    logic        in_taken = 1'b0;
    logic        hold_off = 1'b0;
    int unsigned wait_left = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Idle length: mostly a few cycles, now and then a long pause.
    function automatic int unsigned idle_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_request(input logic op, input logic [FEATURES_W-1:0] pat,
                                 input logic [CLASS_ID_W-1:0] cls, input bit no_gap);
        request_t req;
        req.opcode   = op;
        req.features = pat;
        req.class_id = cls;
        req.gap      = (no_gap || $urandom_range(0, 1)) ? 0 : idle_length();
        request_queue = {request_queue, req};
    endtask

    // Update the shadow tables for a training request, or work out the results of a query.
    task automatic predict_frequencies(input logic op, input logic [FEATURES_W-1:0] pat,
                                       input logic [CLASS_ID_W-1:0] cls);
        logic [COUNT_BITS-1:0] total;
        logic [31:0]           scaled;
        frequency_t            res;
        if (op == OP_TRAIN) begin
            if (cls < CLASS_COUNT) begin
                if (!(&class_tally[pat][cls]))
                    class_tally[pat][cls] = class_tally[pat][cls] + 1'b1;
                if (!(&pattern_tally[pat]))
                    pattern_tally[pat] = pattern_tally[pat] + 1'b1;
                seen_mask[cls] = 1'b1;
            end
        end else begin
            total = pattern_tally[pat];
            if (total == '0) begin
                res = '{matched: 1'b0, out_class: '0, probability: '0, last: 1'b1};
                frequency_queue = {frequency_queue, res};
            end else begin
                for (int c = 0; c < OUT_CLASSES; c++) begin
                    if (seen_mask[c]) begin
                        scaled = {class_tally[pat][c], 16'h0000} / total;
                        res.matched     = 1'b1;
                        res.out_class   = OUT_CLASS_W'(c);
                        res.probability = scaled[PROB_BITS-1:0];
                        res.last        = 1'b0;
                        frequency_queue = {frequency_queue, res};
                    end
                end
                // A trained pattern implies at least one seen class.
                frequency_queue[frequency_queue.size() - 1].last = 1'b1;
            end
        end
    endtask

    // Request driver: offers the next pending request after its idle gap.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (request_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (wait_left < request_queue[0].gap) begin
                s_tvalid <= 1'b0;
                wait_left++;
            end else begin
                s_tdata  <= {5'b00000, request_queue[0].class_id, request_queue[0].features};
                s_tuser  <= request_queue[0].opcode;
                s_tvalid <= 1'b1;
                wait_left = 0;
                void'(request_queue.pop_front());
            end
        end
    end

    // Input monitor: every accepted request goes through the predictor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                predict_frequencies(s_tuser, s_tdata[7:0], s_tdata[10:8]);
        end
    end

    // Result receiver: random stalls, calm stretches, and the long hold-off.
    always @(negedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) < 4)
                calm_left = $urandom_range(50, 300);
            else if ($urandom_range(0, 99) < 25)
                stall_left = idle_length();
        end
    end

    // Result monitor: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        frequency_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (frequency_queue.size() == 0) begin
                report_mismatch("unexpected result, class", m_tdata[3:1], 0);
            end else begin
                want = frequency_queue.pop_front();
                if (m_tdata[0] !== want.matched)
                    report_mismatch("matched", m_tdata[0], want.matched);
                if (m_tdata[3:1] !== want.out_class)
                    report_mismatch("out_class", m_tdata[3:1], want.out_class);
                if (m_tdata[20:4] !== want.probability)
                    report_mismatch("probability", m_tdata[20:4], want.probability);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // Hold the result side off long enough for the block to back up its input.
    initial begin
        while (results_seen < 60)
            @(posedge aclk);
        hold_off = 1'b1;
        repeat (700) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Run limit, well above the slowest correct run.
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [FEATURES_W-1:0] hot_patterns [16];
        logic [FEATURES_W-1:0] pat;
        logic [CLASS_ID_W-1:0] favorite;
        int unsigned random_items;
        int unsigned burst;
        int unsigned roll;
        bit          busy;

        for (int p = 0; p < PATTERN_DEPTH; p++) begin
            pattern_tally[p] = '0;
            for (int c = 0; c < CLASS_COUNT; c++)
                class_tally[p][c] = '0;
        end
        seen_mask = '0;

        // Directed requests: empty tables, field extremes, absent and unseen classes.
        queue_request(OP_QUERY, 8'h00, 3'd5, 1'b0);   // nothing trained yet
        queue_request(OP_TRAIN, 8'h00, 3'd0, 1'b0);
        queue_request(OP_QUERY, 8'h00, 3'd0, 1'b0);   // single class, full fraction
        queue_request(OP_TRAIN, 8'hFF, 3'd7, 1'b0);
        queue_request(OP_QUERY, 8'h00, 3'd7, 1'b0);   // seen class absent here
        queue_request(OP_QUERY, 8'hFF, 3'd0, 1'b0);
        queue_request(OP_TRAIN, 8'hFF, 3'd3, 1'b0);
        queue_request(OP_TRAIN, 8'hFF, 3'd3, 1'b0);
        queue_request(OP_QUERY, 8'hFF, 3'd2, 1'b0);   // thirds truncate
        queue_request(OP_QUERY, 8'h5A, 3'd7, 1'b0);   // unknown pattern after training
        queue_request(OP_TRAIN, 8'hA5, 3'd1, 1'b0);
        queue_request(OP_TRAIN, 8'hA5, 3'd2, 1'b0);
        queue_request(OP_TRAIN, 8'hA5, 3'd4, 1'b0);
        queue_request(OP_TRAIN, 8'hA5, 3'd5, 1'b0);
        queue_request(OP_TRAIN, 8'hA5, 3'd6, 1'b0);
        queue_request(OP_TRAIN, 8'hA5, 3'd6, 1'b0);
        queue_request(OP_QUERY, 8'hA5, 3'd1, 1'b0);   // all eight classes reported
        queue_request(OP_QUERY, 8'hFF, 3'd6, 1'b0);

        // Random part: mostly train runs on a few hot patterns followed by a query.
        for (int i = 0; i < 16; i++)
            hot_patterns[i] = 8'($urandom);
        random_items = 0;
        while (random_items < 450) begin
            roll = $urandom_range(0, 99);
            busy = ($urandom_range(0, 4) == 0);
            if (roll < 70) begin
                pat      = hot_patterns[$urandom_range(0, 15)];
                favorite = 3'($urandom_range(0, 7));
                burst    = $urandom_range(1, 6);
                repeat (burst)
                    queue_request(OP_TRAIN, pat,
                                  $urandom_range(0, 1) ? favorite : 3'($urandom_range(0, 7)),
                                  busy);
                queue_request(OP_QUERY, pat, 3'($urandom_range(0, 7)), busy);
                random_items += burst + 1;
            end else if (roll < 85) begin
                queue_request(OP_QUERY, 8'($urandom), 3'($urandom_range(0, 7)), busy);
                random_items++;
            end else begin
                queue_request(OP_TRAIN, 8'($urandom), 3'($urandom_range(0, 7)), busy);
                random_items++;
            end
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: all requests taken, all results in, then a quiet tail.
        while (request_queue.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (frequency_queue.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
